@@ design/line_position_estimator_defines.svh @@
// Assertion macros shared by the line position estimator RTL.
`ifndef LINE_POSITION_ESTIMATOR_DEFINES_SVH
`define LINE_POSITION_ESTIMATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset.
`define LPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define LPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPE_ASSERT(lbl, prop, msg)
`define LPE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/lpe_pkg.sv @@
// Types and constants of the line position estimator.
package lpe_pkg;

  localparam int NSENS      = 4;
  localparam int SENS_W     = 2;
  localparam int SAMPLE_W   = 10;
  localparam int SAMPLE_MAX = 1000;
  localparam int THR_W      = 10;
  localparam int THR_MAX    = 1023;
  localparam int OFF_W      = 10;
  localparam int GAIN_W     = 12;
  localparam int ERR_W      = 15;
  localparam int ERR_LIMIT  = 10000;
  localparam int CODE_W     = 2;

  // Quotient bits of the centroid divide: |centroid| <= 512, scale <= 40950/256.
  localparam int Q_W        = 17;
  localparam int CNT_W      = 5;

  // Result case codes
  localparam logic [CODE_W-1:0] CASE_CENTROID = 2'd0;
  localparam logic [CODE_W-1:0] CASE_EDGE     = 2'd1;
  localparam logic [CODE_W-1:0] CASE_LOST     = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_3  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd5;

  // Register reset values
  localparam logic [THR_W-1:0]  THR_RST  = 10'd100;
  localparam logic [OFF_W-1:0]  OFF0_RST = 10'h35B;  // -165
  localparam logic [OFF_W-1:0]  OFF1_RST = 10'h3A6;  // -90
  localparam logic [OFF_W-1:0]  OFF2_RST = 10'd90;
  localparam logic [OFF_W-1:0]  OFF3_RST = 10'd165;
  localparam logic [GAIN_W-1:0] GAIN_RST = 12'd1551;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
  } in_beat_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] error_hundredths;
    logic [CODE_W-1:0]       case_code;
  } out_beat_t;

  typedef struct packed {
    logic [THR_W-1:0]             threshold;
    logic [NSENS-1:0][OFF_W-1:0]  offset;
    logic [GAIN_W-1:0]            gain;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;
    logic              acc_en;
    logic [SENS_W-1:0] sensor;
    logic              mul_en;
    logic              scale_en;
    logic              div_init;
    logic              div_step;
    logic              finish;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic seen;
    logic low_sum;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/line_position_estimator.sv @@
// Line position estimator top level: configuration registers and core wiring.
//
// Takes one beat of four reflectance samples at a time and returns one result
// beat per input: the line error in hundredths of percent and a case code
// (centroid, edge sensor, line lost). A weighted centroid result passes a
// serial accumulate over the four sensors, one multiply and one scale stage,
// then the setup step and the 17 steps of the restoring divider; results for
// the edge and line-lost cases skip the divider. in_stall_o is high while an
// item is in flight; a finished result sits in the output register until
// taken. The next item may be accepted once a result is in that register,
// and its own result waits until the register is free.
// Configuration writes are taken in any cycle and must happen while idle.
// The moving-average rings start cleared after reset with no warm-up pass.
module line_position_estimator #(
  parameter int FILTER_DEPTH = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lpe_pkg::in_beat_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lpe_pkg::out_beat_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lpe_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lpe_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  lpe_pkg::cfg_t       cfg_q;
  lpe_pkg::dp_cmd_t    cmd;
  lpe_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= lpe_pkg::THR_RST;
      cfg_q.offset[0] <= lpe_pkg::OFF0_RST;
      cfg_q.offset[1] <= lpe_pkg::OFF1_RST;
      cfg_q.offset[2] <= lpe_pkg::OFF2_RST;
      cfg_q.offset[3] <= lpe_pkg::OFF3_RST;
      cfg_q.gain      <= lpe_pkg::GAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lpe_pkg::REG_THRESHOLD: cfg_q.threshold <= cfg_data_i[lpe_pkg::THR_W-1:0];
        lpe_pkg::REG_OFFSET_0:  cfg_q.offset[0] <= cfg_data_i[lpe_pkg::OFF_W-1:0];
        lpe_pkg::REG_OFFSET_1:  cfg_q.offset[1] <= cfg_data_i[lpe_pkg::OFF_W-1:0];
        lpe_pkg::REG_OFFSET_2:  cfg_q.offset[2] <= cfg_data_i[lpe_pkg::OFF_W-1:0];
        lpe_pkg::REG_OFFSET_3:  cfg_q.offset[3] <= cfg_data_i[lpe_pkg::OFF_W-1:0];
        lpe_pkg::REG_GAIN:      cfg_q.gain      <= cfg_data_i[lpe_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lpe_datapath #(
    .FILTER_DEPTH (FILTER_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ design/lpe_ctrl.sv @@
// Sequencer of the line position estimator: one item at a time.
module lpe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lpe_pkg::dp_status_t status_i,
  output lpe_pkg::dp_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_DIVI  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]                state_q, state_d;
  logic [lpe_pkg::CNT_W-1:0] cnt_q, cnt_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.sensor = cnt_q[lpe_pkg::SENS_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (cnt_q == lpe_pkg::CNT_W'(lpe_pkg::NSENS - 1)) begin
          state_d = S_MUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale_en = 1'b1;
        // lost line and weak line need no divide
        if (!status_i.seen || status_i.low_sum) begin
          state_d = S_FIN;
        end else begin
          state_d = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == lpe_pkg::CNT_W'(lpe_pkg::Q_W - 1)) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ design/lpe_datapath.sv @@
// Datapath: sample rings, running sums, centroid accumulate, scale and divide.
`include "line_position_estimator_defines.svh"

module lpe_datapath #(
  parameter int FILTER_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpe_pkg::dp_cmd_t    cmd_i,
  output lpe_pkg::dp_status_t status_o,
  input  lpe_pkg::cfg_t       cfg_i,
  input  lpe_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpe_pkg::out_beat_t  out_data_o
);

  localparam int SLOT_W  = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int SUM_W   = $clog2(lpe_pkg::SAMPLE_MAX * FILTER_DEPTH + 1);
  localparam int LIMIT_W = $clog2(lpe_pkg::THR_MAX * FILTER_DEPTH + 1);
  localparam int DEN_W   = SUM_W + 2;
  localparam int NUM_W   = SUM_W + 12;
  localparam int P_W     = NUM_W + 13;
  localparam int X_W     = P_W + 4;
  localparam int MAG_W   = X_W - 8;
  localparam int NS      = lpe_pkg::NSENS;
  localparam int SW      = lpe_pkg::SAMPLE_W;
  localparam int EW      = lpe_pkg::ERR_W;
  localparam int QW      = lpe_pkg::Q_W;

  localparam logic [EW-1:0] ERR_POS = EW'(lpe_pkg::ERR_LIMIT);
  localparam logic [EW-1:0] ERR_NEG = EW'(-lpe_pkg::ERR_LIMIT);

  // ring storage; a slot that was never written counts as zero in the sums
  logic [SW-1:0]           ring_q [NS][FILTER_DEPTH];
  logic [FILTER_DEPTH-1:0] ring_vld_q;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [SUM_W-1:0]        sums_q [NS];
  logic [SUM_W-1:0]        sums_d [NS];
  logic [SW-1:0]           sat [NS];
  logic [SW-1:0]           raw [NS];

  logic signed [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0]        den_q, den_d;
  logic [SUM_W-1:0]        max_val_q, max_val_d;
  logic [lpe_pkg::SENS_W-1:0] max_idx_q, max_idx_d;
  logic                    seen_q, seen_d;

  logic [LIMIT_W-1:0]      limit;
  logic [DEN_W-1:0]        limit_den;
  logic [DEN_W-1:0]        limit2;
  logic                    low_sum;

  logic [SUM_W-1:0]        sum_sel;
  logic signed [lpe_pkg::OFF_W-1:0] off_sel;
  logic signed [lpe_pkg::OFF_W-1:0] off_max;
  logic signed [SUM_W+10:0] term;
  logic                    qual;

  logic signed [NUM_W-1:0] mul_a;
  logic signed [lpe_pkg::GAIN_W:0] gain_s;
  logic signed [P_W-1:0]   prod_q, prod_d;

  logic signed [X_W-1:0]   xw, x10;
  logic [X_W-1:0]          absx;
  logic [MAG_W-1:0]        mag_q;
  logic                    neg_q;

  logic [DEN_W-1:0]        rem_q, rem_d;
  logic [QW-1:0]           quo_q, quo_d;
  logic [DEN_W:0]          trial;
  logic                    ge;

  logic [MAG_W-1:0]        sel_mag;
  logic [EW-2:0]           clamped;
  logic [EW-1:0]           mag_ext;
  logic [EW-1:0]           err_val;
  logic signed [EW-1:0]    last_err_q;
  logic                    last_pos;

  lpe_pkg::out_beat_t      out_q, out_d;
  logic                    out_valid_q;

  logic                    err_ok;
  logic                    lost_ok;

  // saturate incoming samples
  assign raw[0] = in_data_i.sample_0;
  assign raw[1] = in_data_i.sample_1;
  assign raw[2] = in_data_i.sample_2;
  assign raw[3] = in_data_i.sample_3;

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      sat[s] = (raw[s] > SW'(lpe_pkg::SAMPLE_MAX)) ? SW'(lpe_pkg::SAMPLE_MAX) : raw[s];
    end
  end

  // running sums: drop the sample leaving the window, add the new one
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      sums_d[s] = sums_q[s]
                - (ring_vld_q[slot_q] ? SUM_W'(ring_q[s][slot_q]) : '0)
                + SUM_W'(sat[s]);
    end
  end

  assign slot_d = (slot_q == SLOT_W'(FILTER_DEPTH - 1)) ? '0 : slot_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int s = 0; s < NS; s++) begin
        ring_q[s][slot_q] <= sat[s];
      end
    end
  end

  // thresholds
  assign limit     = LIMIT_W'(cfg_i.threshold * FILTER_DEPTH);
  assign limit_den = DEN_W'(limit);
  assign limit2    = limit_den << 1;
  assign low_sum   = (den_q < limit2);

  // one sensor per cycle into the centroid sums
  assign sum_sel = sums_q[cmd_i.sensor];
  assign off_sel = $signed(cfg_i.offset[cmd_i.sensor]);
  assign term    = $signed({1'b0, sum_sel}) * off_sel;
  assign qual    = (DEN_W'(sum_sel) > limit_den);

  always_comb begin
    num_d     = num_q;
    den_d     = den_q;
    max_val_d = max_val_q;
    max_idx_d = max_idx_q;
    seen_d    = seen_q;
    if (cmd_i.load) begin
      num_d     = '0;
      den_d     = '0;
      max_val_d = '0;
      max_idx_d = '0;
      seen_d    = 1'b0;
    end else if (cmd_i.acc_en && qual) begin
      num_d  = num_q + NUM_W'(term);
      den_d  = den_q + DEN_W'(sum_sel);
      seen_d = 1'b1;
      if (sum_sel > max_val_q) begin
        max_val_d = sum_sel;
        max_idx_d = cmd_i.sensor;
      end
    end
  end

  // scale by gain: centroid numerator, or the strongest sensor's offset
  assign off_max = $signed(cfg_i.offset[max_idx_q]);
  assign mul_a   = low_sum ? NUM_W'(off_max) : num_q;
  assign gain_s  = $signed({1'b0, cfg_i.gain});
  assign prod_d  = mul_a * gain_s;

  // times ten, magnitude, drop the Q8 fraction
  assign xw   = X_W'(prod_q);
  assign x10  = (xw <<< 3) + (xw <<< 1);
  assign absx = x10[X_W-1] ? X_W'(-x10) : X_W'(x10);

  // restoring divide of the magnitude by the weight sum, one bit a step
  assign trial = {rem_q, quo_q[QW-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.div_init) begin
      rem_d = DEN_W'(mag_q >> QW);
      quo_d = mag_q[QW-1:0];
    end else if (cmd_i.div_step) begin
      rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      quo_d = {quo_q[QW-2:0], ge};
    end
  end

  // clamp, sign and case select
  assign sel_mag  = low_sum ? mag_q : MAG_W'(quo_q);
  assign clamped  = (sel_mag > MAG_W'(lpe_pkg::ERR_LIMIT)) ?
                    (EW-1)'(lpe_pkg::ERR_LIMIT) : sel_mag[EW-2:0];
  assign mag_ext  = {1'b0, clamped};
  assign err_val  = neg_q ? EW'(-mag_ext) : mag_ext;
  assign last_pos = !last_err_q[EW-1] && (last_err_q != '0);

  always_comb begin
    if (!seen_q) begin
      out_d.error_hundredths = last_pos ? ERR_POS : ERR_NEG;
      out_d.case_code        = lpe_pkg::CASE_LOST;
    end else if (low_sum) begin
      out_d.error_hundredths = err_val;
      out_d.case_code        = lpe_pkg::CASE_EDGE;
    end else begin
      out_d.error_hundredths = err_val;
      out_d.case_code        = lpe_pkg::CASE_CENTROID;
    end
  end

  // state with defined reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q  <= '0;
      slot_q      <= '0;
      for (int s = 0; s < NS; s++) begin
        sums_q[s] <= '0;
      end
      last_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        ring_vld_q[slot_q] <= 1'b1;
        slot_q             <= slot_d;
        for (int s = 0; s < NS; s++) begin
          sums_q[s] <= sums_d[s];
        end
      end
      if (cmd_i.finish && seen_q && !low_sum) begin
        last_err_q <= $signed(err_val);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    num_q     <= num_d;
    den_q     <= den_d;
    max_val_q <= max_val_d;
    max_idx_q <= max_idx_d;
    seen_q    <= seen_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.scale_en) begin
      mag_q <= absx[X_W-1:8];
      neg_q <= x10[X_W-1];
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  assign status_o.seen     = seen_q;
  assign status_o.low_sum  = low_sum;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

  // result checks
  assign err_ok  = ($signed(out_q.error_hundredths) <= 15'sd10000) &&
                   ($signed(out_q.error_hundredths) >= -15'sd10000);
  assign lost_ok = (out_q.case_code != lpe_pkg::CASE_LOST) ||
                   (out_q.error_hundredths == ERR_POS) ||
                   (out_q.error_hundredths == ERR_NEG);

  `LPE_ASSERT(err_in_range, !out_valid_q || err_ok, "result error outside +/-10000")
  `LPE_ASSERT(lost_is_full_scale, !out_valid_q || lost_ok, "line lost result not full scale")
  `LPE_ASSERT(div_den_nonzero, !cmd_i.div_init || (den_q != '0), "divide with zero weight sum")
  `LPE_ASSERT_NEXT(finish_shows_beat, cmd_i.finish, out_valid_q, "finished result not presented")

endmodule
